[src/charger_start_sequencer_core_assert.svh]
// assertion macros for the charger start sequencer core
// used by charger_start_sequencer_core.sv, no other dependencies
`ifndef CHARGER_START_SEQUENCER_CORE_ASSERT_SVH
`define CHARGER_START_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("charger start sequencer assertion failed");
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("charger start sequencer assertion failed");
`else
`define CSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/css_pkg.sv]
// shared types and constants for the charger start sequencer
// used by css_ctrl, css_datapath and charger_start_sequencer_core
`timescale 1ns / 1ps

package css_pkg;

    localparam int TICK_W    = 10;
    localparam int HOLD_W    = 16;
    localparam int TIMER_W   = 17;
    localparam int COUNT_W   = 10;
    localparam int OFFSET_W  = 16;
    localparam int VOLT_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = 4;

    localparam logic [HOLD_W-1:0]   HOLD_TIME_RESET     = 16'd1200;
    localparam logic [COUNT_W-1:0]  CALIB_SAMPLES_RESET = 10'd100;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET        = 16'd33456;
    localparam logic [TIMER_W-1:0]  TIMER_MAX           = 17'h1FFFF;
    localparam logic [COUNT_W-1:0]  COUNT_MAX           = 10'h3FF;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX          = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = 1'd1;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CALIB = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_RUN   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_APPLY,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_step;
        logic apply;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_calib;
        logic div_last;
        logic out_free;
    } ctrl_status_t;

endpackage

[src/charger_start_sequencer_core.sv]
// charger start sequencer, top level
// depends on css_pkg, css_ctrl, css_datapath and charger_start_sequencer_core_assert.svh
//
// one input transaction per tick (in_valid / in_stall) gives exactly one result
// transaction (out_valid / out_stall) holding the mode, switch drive, current
// offset, latched start voltage and the start_control pulse after that tick.
// a tick is taken only while the controller is idle; a calibration tick runs a
// 16-step restoring divider for the running mean between its exec and apply
// steps, other ticks go from exec to output directly. the divider sets the rate
// for calibration ticks, the controller's exec and output steps set it otherwise.
// the result register lets the next tick be taken while a result still waits;
// while out_stall holds a result, a finished tick waits in the controller and
// in_stall stays high.
// cfg_we writes hold_time_ms (index 0) or calib_samples (index 1) from cfg_data
// on any clock edge, meant only while the block is idle.
// asynchronous active-low reset returns to idle mode with the switch off,
// offset 2091.0 in 12.4 format and configuration at 1200 ms and 100 samples.
`timescale 1ns / 1ps
`include "charger_start_sequencer_core_assert.svh"

module charger_start_sequencer_core
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [css_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [css_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [css_pkg::TICK_W-1:0]      tick_ms,
    input  logic                            start_request,
    input  logic [SAMPLE_BITS-1:0]          current_sample,
    input  logic                            battery_present,
    input  logic [css_pkg::VOLT_W-1:0]      battery_voltage_mv,
    input  logic                            force_idle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      mode,
    output logic                            switch_on,
    output logic [css_pkg::OFFSET_W-1:0]    current_offset,
    output logic [css_pkg::VOLT_W-1:0]      initial_voltage_mv,
    output logic                            start_control
);

    css_pkg::ctrl_cmd_t    cmd;
    css_pkg::ctrl_status_t status;

    css_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    css_datapath
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .tick_ms            (tick_ms),
        .start_request      (start_request),
        .current_sample     (current_sample),
        .battery_present    (battery_present),
        .battery_voltage_mv (battery_voltage_mv),
        .force_idle         (force_idle),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .mode               (mode),
        .switch_on          (switch_on),
        .current_offset     (current_offset),
        .initial_voltage_mv (initial_voltage_mv),
        .start_control      (start_control),
        .cmd                (cmd),
        .status             (status)
    );

    // a start pulse only comes with running mode and the switch on
    `CSS_ASSERT_IMP(a_pulse_running, clk, rst_n, out_valid && start_control, mode == css_pkg::MODE_RUN && switch_on)
    // a stalled result stays valid and unchanged
    `CSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(current_offset))
    // the controller takes one tick at a time
    `CSS_ASSERT_NEXT(a_single_item, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

[src/css_ctrl.sv]
// controller state machine of the charger start sequencer
// depends on css_pkg
`timescale 1ns / 1ps

module css_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  css_pkg::ctrl_status_t status,
    output css_pkg::ctrl_cmd_t    cmd
);

    css_pkg::ctrl_state_t state_reg;
    css_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= css_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            css_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = css_pkg::ST_EXEC;
                end
            end
            css_pkg::ST_EXEC:
            begin
                state_next = status.is_calib ? css_pkg::ST_DIV : css_pkg::ST_OUT;
            end
            css_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = css_pkg::ST_APPLY;
                end
            end
            css_pkg::ST_APPLY:
            begin
                state_next = css_pkg::ST_OUT;
            end
            css_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = css_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = css_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            css_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            css_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            css_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            css_pkg::ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            css_pkg::ST_OUT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/css_datapath.sv]
// datapath of the charger start sequencer: state registers, serial divider,
// configuration registers and output register; depends on css_pkg
`timescale 1ns / 1ps

module css_datapath
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [css_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [css_pkg::CFG_W-1:0]       cfg_data,
    input  logic [css_pkg::TICK_W-1:0]      tick_ms,
    input  logic                            start_request,
    input  logic [SAMPLE_BITS-1:0]          current_sample,
    input  logic                            battery_present,
    input  logic [css_pkg::VOLT_W-1:0]      battery_voltage_mv,
    input  logic                            force_idle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      mode,
    output logic                            switch_on,
    output logic [css_pkg::OFFSET_W-1:0]    current_offset,
    output logic [css_pkg::VOLT_W-1:0]      initial_voltage_mv,
    output logic                            start_control,
    input  css_pkg::ctrl_cmd_t              cmd,
    output css_pkg::ctrl_status_t           status
);

    localparam int XW = (SAMPLE_BITS > 12) ? SAMPLE_BITS + 4 : 16;

    // configuration
    logic [css_pkg::HOLD_W-1:0]   hold_time_reg;
    logic [css_pkg::COUNT_W-1:0]  calib_samples_reg;

    // captured transaction
    logic [css_pkg::TICK_W-1:0]   tick_q_reg;
    logic                         req_q_reg;
    logic [SAMPLE_BITS-1:0]       sample_q_reg;
    logic                         present_q_reg;
    logic [css_pkg::VOLT_W-1:0]   volts_q_reg;
    logic                         force_q_reg;

    // sequencer state
    css_pkg::mode_t               mode_reg,          mode_next;
    logic [css_pkg::TIMER_W-1:0]  hold_timer_reg,    hold_timer_next;
    logic                         request_latch_reg, request_latch_next;
    logic [css_pkg::COUNT_W-1:0]  mean_count_reg,    mean_count_next;
    logic [css_pkg::OFFSET_W-1:0] offset_mean_reg,   offset_mean_next;
    logic [css_pkg::VOLT_W-1:0]   voltage_latch_reg, voltage_latch_next;
    logic                         switch_reg,        switch_next;
    logic                         pulse_reg,         pulse_next;

    // serial divider
    logic [css_pkg::OFFSET_W-1:0]  quot_reg,    quot_next;
    logic [css_pkg::COUNT_W-1:0]   rem_reg,     rem_next;
    logic [css_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                          neg_reg,     neg_next;

    // output register
    logic                         out_valid_reg;
    logic [1:0]                   out_mode_reg;
    logic                         out_switch_reg;
    logic [css_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [css_pkg::VOLT_W-1:0]   out_volt_reg;
    logic                         out_pulse_reg;

    logic                         req_eff;
    css_pkg::mode_t               mode_eff;
    logic [css_pkg::TIMER_W:0]    timer_sum;
    logic [css_pkg::TIMER_W-1:0]  timer_sat;
    logic [XW-1:0]                x_wide;
    logic [css_pkg::OFFSET_W-1:0] x_val;
    logic [css_pkg::COUNT_W:0]    trial;
    logic                         trial_ge;

    assign req_eff  = req_q_reg | request_latch_reg;
    assign mode_eff = force_q_reg ? css_pkg::MODE_IDLE : mode_reg;

    assign timer_sum = {1'b0, hold_timer_reg} + (css_pkg::TIMER_W + 1)'(tick_q_reg);
    assign timer_sat = timer_sum[css_pkg::TIMER_W] ? css_pkg::TIMER_MAX
                                                   : timer_sum[css_pkg::TIMER_W-1:0];

    assign x_wide = XW'({sample_q_reg, 4'b0000});
    assign x_val  = (x_wide > XW'(css_pkg::OFFSET_MAX)) ? css_pkg::OFFSET_MAX
                                                        : x_wide[css_pkg::OFFSET_W-1:0];

    assign trial    = {rem_reg, quot_reg[css_pkg::OFFSET_W-1]};
    assign trial_ge = trial >= {1'b0, mean_count_reg};

    assign status.is_calib = (mode_eff == css_pkg::MODE_CALIB);
    assign status.div_last = (div_cnt_reg == css_pkg::DIV_CNT_W'(css_pkg::OFFSET_W - 1));
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg     <= css_pkg::HOLD_TIME_RESET;
            calib_samples_reg <= css_pkg::CALIB_SAMPLES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                css_pkg::REG_HOLD_TIME:     hold_time_reg     <= cfg_data;
                css_pkg::REG_CALIB_SAMPLES: calib_samples_reg <= cfg_data[css_pkg::COUNT_W-1:0];
                default:                    hold_time_reg     <= hold_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tick_q_reg    <= tick_ms;
            req_q_reg     <= start_request;
            sample_q_reg  <= current_sample;
            present_q_reg <= battery_present;
            volts_q_reg   <= battery_voltage_mv;
            force_q_reg   <= force_idle;
        end
    end

    always_comb
    begin
        mode_next          = mode_reg;
        hold_timer_next    = hold_timer_reg;
        request_latch_next = request_latch_reg;
        mean_count_next    = mean_count_reg;
        offset_mean_next   = offset_mean_reg;
        voltage_latch_next = voltage_latch_reg;
        switch_next        = switch_reg;
        pulse_next         = pulse_reg;
        quot_next          = quot_reg;
        rem_next           = rem_reg;
        div_cnt_next       = div_cnt_reg;
        neg_next           = neg_reg;

        if (cmd.exec)
        begin
            request_latch_next = req_eff;
            mode_next          = mode_eff;
            pulse_next         = 1'b0;
            unique case (mode_eff)
                css_pkg::MODE_IDLE:
                begin
                    if (req_eff)
                    begin
                        if (timer_sat >= {1'b0, hold_time_reg})
                        begin
                            mode_next       = css_pkg::MODE_CALIB;
                            hold_timer_next = '0;
                        end
                        else
                        begin
                            hold_timer_next = timer_sat;
                        end
                    end
                    else
                    begin
                        hold_timer_next = '0;
                    end
                end
                css_pkg::MODE_CALIB:
                begin
                    switch_next = 1'b0;
                    if (mean_count_reg != css_pkg::COUNT_MAX)
                    begin
                        mean_count_next = mean_count_reg + 1'b1;
                    end
                    neg_next     = x_val < offset_mean_reg;
                    quot_next    = (x_val < offset_mean_reg) ? offset_mean_reg - x_val
                                                             : x_val - offset_mean_reg;
                    rem_next     = '0;
                    div_cnt_next = '0;
                end
                css_pkg::MODE_CHECK:
                begin
                    if (present_q_reg)
                    begin
                        voltage_latch_next = volts_q_reg;
                        switch_next        = 1'b1;
                        pulse_next         = 1'b1;
                        mode_next          = css_pkg::MODE_RUN;
                    end
                    else
                    begin
                        request_latch_next = 1'b0;
                        mode_next          = css_pkg::MODE_IDLE;
                    end
                end
                css_pkg::MODE_RUN:
                begin
                    mode_next = css_pkg::MODE_RUN;
                end
                default:
                begin
                    mode_next = mode_eff;
                end
            endcase
        end

        if (cmd.div_step)
        begin
            rem_next     = trial_ge ? trial[css_pkg::COUNT_W-1:0]
                                      - mean_count_reg
                                    : trial[css_pkg::COUNT_W-1:0];
            quot_next    = {quot_reg[css_pkg::OFFSET_W-2:0], trial_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        if (cmd.apply)
        begin
            offset_mean_next = neg_reg ? offset_mean_reg - quot_reg
                                       : offset_mean_reg + quot_reg;
            if (mean_count_reg >= calib_samples_reg)
            begin
                mode_next = css_pkg::MODE_CHECK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= css_pkg::MODE_IDLE;
            hold_timer_reg    <= '0;
            request_latch_reg <= 1'b0;
            mean_count_reg    <= '0;
            offset_mean_reg   <= css_pkg::OFFSET_RESET;
            voltage_latch_reg <= '0;
            switch_reg        <= 1'b0;
            pulse_reg         <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            mode_reg          <= mode_next;
            hold_timer_reg    <= hold_timer_next;
            request_latch_reg <= request_latch_next;
            mean_count_reg    <= mean_count_next;
            offset_mean_reg   <= offset_mean_next;
            voltage_latch_reg <= voltage_latch_next;
            switch_reg        <= switch_next;
            pulse_reg         <= pulse_next;
            div_cnt_reg       <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mode_reg   <= mode_reg;
            out_switch_reg <= switch_reg;
            out_offset_reg <= offset_mean_reg;
            out_volt_reg   <= voltage_latch_reg;
            out_pulse_reg  <= pulse_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign mode               = out_mode_reg;
    assign switch_on          = out_switch_reg;
    assign current_offset     = out_offset_reg;
    assign initial_voltage_mv = out_volt_reg;
    assign start_control      = out_pulse_reg;

endmodule

[tb/css_tick_checker.sv]
`timescale 1ns / 1ps
// result checker for charger_start_sequencer_core: predicts the outputs of every tick
// and compares them field by field; depends on css_pkg, instantiated by tb_top

module css_tick_checker
    import css_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [TICK_W-1:0]      tick_ms,
    input  logic                   start_request,
    input  logic [SAMPLE_BITS-1:0] current_sample,
    input  logic                   battery_present,
    input  logic [VOLT_W-1:0]      battery_voltage_mv,
    input  logic                   force_idle,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [1:0]             mode,
    input  logic                   switch_on,
    input  logic [OFFSET_W-1:0]    current_offset,
    input  logic [VOLT_W-1:0]      initial_voltage_mv,
    input  logic                   start_control,
    output int                     mismatches,
    output int                     pending
);

    typedef struct packed {
        mode_t               mode;
        logic                switch_on;
        logic [OFFSET_W-1:0] offset;
        logic [VOLT_W-1:0]   voltage;
        logic                start_pulse;
    } tick_result_t;

    logic [HOLD_W-1:0]   hold_limit;
    logic [COUNT_W-1:0]  calib_target;
    mode_t               seq_mode;
    logic [TIMER_W-1:0]  hold_acc;
    logic                req_held;
    logic [COUNT_W-1:0]  sample_cnt;
    logic [OFFSET_W-1:0] offset_avg;
    logic [VOLT_W-1:0]   volt_held;
    logic                switch_held;
    tick_result_t        expected_ticks[$];
    tick_result_t        want;
    int                  error_total;

    function automatic tick_result_t advance_tick(
        input logic [TICK_W-1:0]      ms,
        input logic                   req,
        input logic [SAMPLE_BITS-1:0] sample,
        input logic                   present,
        input logic [VOLT_W-1:0]      mv,
        input logic                   idle_req
    );
        tick_result_t r;
        logic [TIMER_W:0] sum;
        int unsigned x;
        int unsigned avg;
        r.start_pulse = 1'b0;
        if (req)
            req_held = 1'b1;
        if (idle_req)
            seq_mode = MODE_IDLE;
        case (seq_mode)
            MODE_IDLE:
            begin
                if (req_held)
                begin
                    sum = {1'b0, hold_acc} + (TIMER_W + 1)'(ms);
                    hold_acc = (sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : sum[TIMER_W-1:0];
                    if (hold_acc >= {1'b0, hold_limit})
                    begin
                        seq_mode = MODE_CALIB;
                        hold_acc = '0;
                    end
                end
                else
                begin
                    hold_acc = '0;
                end
            end
            MODE_CALIB:
            begin
                switch_held = 1'b0;
                x = 32'(sample) << 4;
                if (x > 32'(OFFSET_MAX))
                    x = 32'(OFFSET_MAX);
                if (sample_cnt != COUNT_MAX)
                    sample_cnt = sample_cnt + 1'b1;
                avg = 32'(offset_avg);
                if (x >= avg)
                    avg = avg + (x - avg) / 32'(sample_cnt);
                else
                    avg = avg - (avg - x) / 32'(sample_cnt);
                offset_avg = OFFSET_W'(avg);
                if (sample_cnt >= calib_target)
                    seq_mode = MODE_CHECK;
            end
            MODE_CHECK:
            begin
                if (present)
                begin
                    volt_held = mv;
                    switch_held = 1'b1;
                    r.start_pulse = 1'b1;
                    seq_mode = MODE_RUN;
                end
                else
                begin
                    req_held = 1'b0;
                    seq_mode = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        r.mode = seq_mode;
        r.switch_on = switch_held;
        r.offset = offset_avg;
        r.voltage = volt_held;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        error_total++;
        if (error_total <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
            note_failure($sformatf("%s mismatch: expected %0d, actual %0d",
                                   name, exp_val, act_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_limit = HOLD_TIME_RESET;
            calib_target = CALIB_SAMPLES_RESET;
            seq_mode = MODE_IDLE;
            hold_acc = '0;
            req_held = 1'b0;
            sample_cnt = '0;
            offset_avg = OFFSET_RESET;
            volt_held = '0;
            switch_held = 1'b0;
            expected_ticks.delete();
            error_total = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            // result side first: a tick taken at this edge cannot complete at it
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                begin
                    note_failure("result transaction with no tick outstanding");
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("mode", 32'(want.mode), 32'(mode));
                    check_field("switch_on", 32'(want.switch_on), 32'(switch_on));
                    check_field("current_offset", 32'(want.offset), 32'(current_offset));
                    check_field("initial_voltage_mv", 32'(want.voltage),
                                32'(initial_voltage_mv));
                    check_field("start_control", 32'(want.start_pulse), 32'(start_control));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOLD_TIME:     hold_limit = cfg_data[HOLD_W-1:0];
                    REG_CALIB_SAMPLES: calib_target = cfg_data[COUNT_W-1:0];
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_ticks.push_back(advance_tick(tick_ms, start_request, current_sample,
                                                      battery_present, battery_voltage_mv,
                                                      force_idle));
            mismatches <= error_total;
            pending <= expected_ticks.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// testbench top for charger_start_sequencer_core: clock, reset, tick stimulus,
// register writes and result-side stalls; checking is done by css_tick_checker

module tb_top;
    import css_pkg::*;

    localparam int SAMPLE_BITS     = 12;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1500000;

    typedef struct packed {
        logic [TICK_W-1:0]      ms;
        logic                   req;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   present;
        logic [VOLT_W-1:0]      mv;
        logic                   idle_req;
    } tick_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [TICK_W-1:0]      tick_ms;
    logic                   start_request;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic                   battery_present;
    logic [VOLT_W-1:0]      battery_voltage_mv;
    logic                   force_idle;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             mode;
    logic                   switch_on;
    logic [OFFSET_W-1:0]    current_offset;
    logic [VOLT_W-1:0]      initial_voltage_mv;
    logic                   start_control;
    int                     mismatches;
    int                     pending;
    int                     cycle_count;
    int                     burst_left;
    bit                     hold_off;

    charger_start_sequencer_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (.*);

    css_tick_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic tick_t dtick(input int ms, input bit req, input int sample,
                                    input bit present, input int mv, input bit idle_req);
        tick_t t;
        t.ms = TICK_W'(ms);
        t.req = req;
        t.sample = SAMPLE_BITS'(sample);
        t.present = present;
        t.mv = VOLT_W'(mv);
        t.idle_req = idle_req;
        return t;
    endfunction

    function automatic tick_t random_tick(input int force_pct);
        tick_t t;
        int r;
        r = $urandom_range(0, 99);
        t.ms = (r < 40) ? TICK_W'($urandom_range(0, 15)) : TICK_W'($urandom);
        t.req = ($urandom_range(0, 99) < 70);
        r = $urandom_range(0, 99);
        if (r < 10)
            t.sample = '0;
        else if (r < 20)
            t.sample = '1;
        else
            t.sample = SAMPLE_BITS'($urandom);
        t.present = ($urandom_range(0, 99) < 80);
        t.mv = VOLT_W'($urandom);
        t.idle_req = ($urandom_range(0, 99) < force_pct);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        in_valid <= 1'b1;
        tick_ms <= t.ms;
        start_request <= t.req;
        current_sample <= t.sample;
        battery_present <= t.present;
        battery_voltage_mv <= t.mv;
        force_idle <= t.idle_req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_after_tick();
        int g;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                burst_left = 40;
            g = pick_gap();
            if (g > 0)
            begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic play_script(input tick_t items[$]);
        foreach (items[i])
        begin
            send_tick(items[i]);
            idle_after_tick();
        end
    endtask

    task automatic run_phase(input int hold, input int calib, input int count,
                             input int force_pct, input bit squeeze);
        settle();
        write_reg(REG_HOLD_TIME, CFG_W'(hold));
        write_reg(REG_CALIB_SAMPLES, CFG_W'(calib));
        for (int i = 0; i < count; i++)
        begin
            // receiver holds off while ticks keep coming, so the block backs up
            if (squeeze && i == count / 2)
            begin
                hold_off = 1'b1;
                burst_left = 60;
            end
            send_tick(random_tick(force_pct));
            idle_after_tick();
        end
    endtask

    initial
    begin
        int stall_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                stall_len = pick_gap();
                if (stall_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        tick_t script[$];
        cycle_count = 0;
        burst_left = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        tick_ms = '0;
        start_request = 1'b0;
        current_sample = '0;
        battery_present = 1'b0;
        battery_voltage_mv = '0;
        force_idle = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: request hold, force_idle in idle and calibration, exact hold limit
        script = '{dtick(1023, 0, 4095, 1, 65535, 0), dtick(0, 1, 0, 0, 0, 0),
                   dtick(1023, 0, 2730, 0, 21845, 0), dtick(1023, 0, 1365, 1, 43690, 1),
                   dtick(0, 0, 4095, 0, 0, 0), dtick(0, 0, 0, 1, 65535, 0),
                   dtick(1023, 0, 4095, 1, 0, 1), dtick(177, 0, 0, 0, 0, 0),
                   dtick(0, 0, 2048, 1, 0, 0)};
        play_script(script);
        settle();
        write_reg(REG_CALIB_SAMPLES, CFG_W'(4));

        // check without battery while requesting, start, running, force_idle out of running
        script = '{dtick(5, 0, 1, 1, 0, 0), dtick(0, 1, 0, 0, 12345, 0),
                   dtick(1023, 0, 0, 1, 0, 0), dtick(1023, 1, 0, 1, 0, 0),
                   dtick(1023, 0, 0, 1, 0, 0), dtick(0, 0, 4095, 0, 0, 0),
                   dtick(0, 0, 0, 1, 16'hA5A5, 0), dtick(1023, 1, 4095, 0, 16'h5A5A, 0),
                   dtick(1023, 0, 0, 1, 0, 1), dtick(1023, 0, 0, 1, 0, 0),
                   dtick(0, 0, 0, 1, 0, 0), dtick(0, 0, 0, 1, 65535, 0),
                   dtick(0, 0, 0, 1, 0, 1)};
        play_script(script);

        run_phase(0, 0, 250, 5, 1'b0);
        run_phase(65535, 1, 250, 3, 1'b0);
        run_phase(300, 150, 300, 5, 1'b1);
        run_phase(7, 1023, 700, 5, 1'b0);
        run_phase($urandom_range(0, 3000), $urandom_range(0, 1023), 280, 6, 1'b0);

        settle();
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
